@@ hdl/locd_pkg.sv @@
// shared constants and controller/datapath interface types for the cache directory
`default_nettype none

package locd_pkg;

   localparam int ENTRIES_DEF          = 16;
   localparam int KEY_BITS_DEF         = 32;
   localparam int MAX_OBJECT_BYTES_DEF = 102400;

   localparam int KEY_PORT_W = 32;
   localparam int SIZE_W     = 17;
   localparam int TOTAL_W    = 21;
   localparam int STAMP_W    = 32;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef struct packed {
      logic capture;
      logic search;
      logic reduce;
      logic update;
   } locd_cmd_type;

   typedef struct packed {
      logic evict_needed;
   } locd_stat_type;

endpackage

`default_nettype wire

@@ hdl/locd_ctrl.sv @@
// sequencer for the cache directory: accept, search, lru reduction, update
`default_nettype none

module locd_ctrl #(
   parameter int ENTRIES = locd_pkg::ENTRIES_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  locd_pkg::locd_stat_type stat,
   output locd_pkg::locd_cmd_type  cmd
);
   import locd_pkg::*;

   localparam int LEVELS = $clog2(ENTRIES);
   localparam int LVL_W  = $clog2(LEVELS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_REDUCE,
      ST_UPDATE
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.search  = (state_ff == ST_SEARCH);
      cmd.reduce  = (state_ff == ST_REDUCE);
      // result is written only once the output register is free
      cmd.update  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.evict_needed) begin
               state_in = ST_REDUCE;
               level_in = LVL_W'(LEVELS - 1);
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_REDUCE: begin
            if (level_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               level_in = level_ff - 1'b1;
            end
         end
         ST_UPDATE: begin
            if (cmd.update) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/locd_dpath.sv @@
// entry registers, key match, free search, min-stamp tree and result register
`default_nettype none

module locd_dpath #(
   parameter int ENTRIES          = locd_pkg::ENTRIES_DEF,
   parameter int KEY_BITS         = locd_pkg::KEY_BITS_DEF,
   parameter int MAX_OBJECT_BYTES = locd_pkg::MAX_OBJECT_BYTES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  locd_pkg::locd_cmd_type           cmd,
   output locd_pkg::locd_stat_type          stat,
   input  wire                              req_action,
   input  wire  [locd_pkg::KEY_PORT_W-1:0]  req_key,
   input  wire  [locd_pkg::SIZE_W-1:0]      req_object_size,
   output logic                             rsp_hit,
   output logic [$clog2(ENTRIES)-1:0]       rsp_slot,
   output logic [locd_pkg::SIZE_W-1:0]      rsp_stored_size,
   output logic                             rsp_evicted,
   output logic [locd_pkg::TOTAL_W-1:0]     rsp_total_bytes
);
   import locd_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int NPOW  = 1 << IDX_W;
   localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
   localparam logic [TOTAL_W-1:0] SIZE_CAP = TOTAL_W'(MAX_OBJECT_BYTES);

   // current item
   logic               act_ff, act_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SIZE_W-1:0]  size_ff, size_in;

   // directory entries
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0]   ekey_ff   [ENTRIES];
   logic [KEY_W-1:0]   ekey_in   [ENTRIES];
   logic [SIZE_W-1:0]  esize_ff  [ENTRIES];
   logic [SIZE_W-1:0]  esize_in  [ENTRIES];
   logic [STAMP_W-1:0] estamp_ff [ENTRIES];
   logic [STAMP_W-1:0] estamp_in [ENTRIES];
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // search results
   logic               hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;

   // min-stamp reduction candidates
   logic [STAMP_W-1:0] cand_stamp_ff [NPOW];
   logic [STAMP_W-1:0] cand_stamp_in [NPOW];
   logic [IDX_W-1:0]   cand_idx_ff   [NPOW];
   logic [IDX_W-1:0]   cand_idx_in   [NPOW];
   logic [NPOW-1:0]    cand_live_ff, cand_live_in;

   // result register
   logic               rhit_ff, rhit_in;
   logic [IDX_W-1:0]   rslot_ff, rslot_in;
   logic [SIZE_W-1:0]  rsize_ff, rsize_in;
   logic               revict_ff, revict_in;

   logic [ENTRIES-1:0] match;
   logic               match_any;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [STAMP_W-1:0] stamp_next;
   logic               is_insert;
   logic               full;
   logic [IDX_W-1:0]   target;
   logic [IDX_W-1:0]   sel_idx;
   logic [SIZE_W-1:0]  sel_size;
   logic [TOTAL_W-1:0] total_sub;
   logic [TOTAL_W:0]   total_sum;
   logic               take_r;

   assign is_insert = (act_ff == ACT_INSERT);
   assign full      = &valid_ff;
   assign stat.evict_needed = is_insert && full;

   // parallel key compare and first-match / first-free priority pick
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (ekey_ff[i] == key_ff);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_any = 1'b1;
            match_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign stamp_next = (counter_ff == '1) ? counter_ff : counter_ff + 1'b1;
   assign target     = full ? cand_idx_ff[0] : free_idx_ff;
   assign sel_idx    = is_insert ? target : hit_idx_ff;
   assign sel_size   = esize_ff[sel_idx];

   always_comb begin
      total_sub = total_ff;
      if (full) begin
         total_sub = (total_ff >= TOTAL_W'(sel_size)) ? total_ff - TOTAL_W'(sel_size) : '0;
      end
      total_sum = {1'b0, total_sub} + (TOTAL_W + 1)'(size_ff);
   end

   // item capture and search registers
   always_comb begin
      act_in       = act_ff;
      key_in       = key_ff;
      size_in      = size_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      free_idx_in  = free_idx_ff;
      if (cmd.capture) begin
         act_in  = req_action;
         key_in  = req_key[KEY_W-1:0];
         size_in = (TOTAL_W'(req_object_size) > SIZE_CAP) ? SIZE_W'(SIZE_CAP)
                                                          : req_object_size;
      end
      if (cmd.search) begin
         hit_found_in = match_any;
         hit_idx_in   = match_idx;
         free_idx_in  = free_idx;
      end
   end

   // pairwise tree, one level a cycle; left wins ties so lowest index survives
   always_comb begin
      take_r = 1'b0;
      for (int k = 0; k < NPOW; k++) begin
         cand_stamp_in[k] = cand_stamp_ff[k];
         cand_idx_in[k]   = cand_idx_ff[k];
         cand_live_in[k]  = cand_live_ff[k];
      end
      if (cmd.search) begin
         for (int k = 0; k < NPOW; k++) begin
            cand_idx_in[k] = IDX_W'(k);
            if (k < ENTRIES) begin
               cand_stamp_in[k] = estamp_ff[k];
               cand_live_in[k]  = 1'b1;
            end else begin
               cand_stamp_in[k] = '1;
               cand_live_in[k]  = 1'b0;
            end
         end
      end else if (cmd.reduce) begin
         for (int k = 0; k < NPOW / 2; k++) begin
            take_r = cand_live_ff[2*k+1] && (!cand_live_ff[2*k] ||
                     (cand_stamp_ff[2*k+1] < cand_stamp_ff[2*k]));
            cand_stamp_in[k] = take_r ? cand_stamp_ff[2*k+1] : cand_stamp_ff[2*k];
            cand_idx_in[k]   = take_r ? cand_idx_ff[2*k+1]   : cand_idx_ff[2*k];
            cand_live_in[k]  = cand_live_ff[2*k] || cand_live_ff[2*k+1];
         end
         for (int k = NPOW / 2; k < NPOW; k++) begin
            cand_live_in[k] = 1'b0;
         end
      end
   end

   // entry write-back and result
   always_comb begin
      valid_in   = valid_ff;
      counter_in = counter_ff;
      total_in   = total_ff;
      rhit_in    = rhit_ff;
      rslot_in   = rslot_ff;
      rsize_in   = rsize_ff;
      revict_in  = revict_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         ekey_in[i]   = ekey_ff[i];
         esize_in[i]  = esize_ff[i];
         estamp_in[i] = estamp_ff[i];
      end
      if (cmd.update) begin
         if (is_insert) begin
            valid_in[target]  = 1'b1;
            ekey_in[target]   = key_ff;
            esize_in[target]  = size_ff;
            estamp_in[target] = stamp_next;
            counter_in        = stamp_next;
            total_in          = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            rhit_in           = 1'b0;
            rslot_in          = target;
            rsize_in          = '0;
            revict_in         = full;
         end else begin
            revict_in = 1'b0;
            if (hit_found_ff) begin
               estamp_in[hit_idx_ff] = stamp_next;
               counter_in            = stamp_next;
               rhit_in               = 1'b1;
               rslot_in              = hit_idx_ff;
               rsize_in              = sel_size;
            end else begin
               rhit_in  = 1'b0;
               rslot_in = '0;
               rsize_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         counter_ff <= '0;
         total_ff   <= '0;
      end else begin
         valid_ff   <= valid_in;
         counter_ff <= counter_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      size_ff      <= size_in;
      hit_found_ff <= hit_found_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      cand_live_ff <= cand_live_in;
      rhit_ff      <= rhit_in;
      rslot_ff     <= rslot_in;
      rsize_ff     <= rsize_in;
      revict_ff    <= revict_in;
      for (int i = 0; i < ENTRIES; i++) begin
         ekey_ff[i]   <= ekey_in[i];
         esize_ff[i]  <= esize_in[i];
         estamp_ff[i] <= estamp_in[i];
      end
      for (int k = 0; k < NPOW; k++) begin
         cand_stamp_ff[k] <= cand_stamp_in[k];
         cand_idx_ff[k]   <= cand_idx_in[k];
      end
   end

   assign rsp_hit         = rhit_ff;
   assign rsp_slot        = rslot_ff;
   assign rsp_stored_size = rsize_ff;
   assign rsp_evicted     = revict_ff;
   assign rsp_total_bytes = total_ff;

endmodule

`default_nettype wire

@@ hdl/lru_object_cache_directory_unit.sv @@
// top level of the fully associative object cache directory with timestamp lru
// results are registered after the search and update states; an insert into a full
//   directory passes through the min-stamp tree reduction states before the update
// one item at a time: no new item is taken until the current one is written out;
//   the next item is taken while an earlier result still waits in the output register
// reset clears valid bits, use counter, byte total and the handshake; keys, sizes
//   and stamps are not cleared and need no clearing pass
`default_nettype none

module lru_object_cache_directory_unit #(
   parameter int ENTRIES          = locd_pkg::ENTRIES_DEF,
   parameter int KEY_BITS         = locd_pkg::KEY_BITS_DEF,
   parameter int MAX_OBJECT_BYTES = locd_pkg::MAX_OBJECT_BYTES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_action,
   input  wire  [locd_pkg::KEY_PORT_W-1:0]  req_key,
   input  wire  [locd_pkg::SIZE_W-1:0]      req_object_size,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_hit,
   output logic [$clog2(ENTRIES)-1:0]       rsp_slot,
   output logic [locd_pkg::SIZE_W-1:0]      rsp_stored_size,
   output logic                             rsp_evicted,
   output logic [locd_pkg::TOTAL_W-1:0]     rsp_total_bytes
);
   import locd_pkg::*;

   locd_cmd_type  cmd;
   locd_stat_type stat;

   locd_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   locd_dpath #(
      .ENTRIES          (ENTRIES),
      .KEY_BITS         (KEY_BITS),
      .MAX_OBJECT_BYTES (MAX_OBJECT_BYTES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_object_size (req_object_size),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_stored_size (rsp_stored_size),
      .rsp_evicted     (rsp_evicted),
      .rsp_total_bytes (rsp_total_bytes)
   );

endmodule

`default_nettype wire

@@ hdl/locd_checker.sv @@
// port-level checks for the cache directory, bound to the top level
`default_nettype none

module locd_checker #(
   parameter int ENTRIES = locd_pkg::ENTRIES_DEF
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire                              rsp_hit,
   input wire [$clog2(ENTRIES)-1:0]        rsp_slot,
   input wire [locd_pkg::SIZE_W-1:0]       rsp_stored_size,
   input wire                              rsp_evicted,
   input wire [locd_pkg::TOTAL_W-1:0]      rsp_total_bytes
);

   // one item in flight: the block is busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one still in work");

   // a lookup hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("result shows both hit and eviction");

   // misses and inserts report no stored size
   a_miss_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_stored_size == '0)
      else $error("stored size nonzero without a hit");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) &&
      $stable(rsp_total_bytes) && $stable(rsp_hit))
      else $error("stalled result changed");

endmodule

bind lru_object_cache_directory_unit locd_checker #(.ENTRIES(ENTRIES)) u_locd_checker (.*);

`default_nettype wire

@@ tb/lru_object_cache_directory_checker.sv @@
// checker for the cache directory: predicts each result from accepted items and compares

module lru_object_cache_directory_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_stall,
   input  wire                              req_action,
   input  wire  [locd_pkg::KEY_PORT_W-1:0]  req_key,
   input  wire  [locd_pkg::SIZE_W-1:0]      req_object_size,
   input  wire                              rsp_valid,
   input  wire                              rsp_stall,
   input  wire                              rsp_hit,
   input  wire  [$clog2(locd_pkg::ENTRIES_DEF)-1:0] rsp_slot,
   input  wire  [locd_pkg::SIZE_W-1:0]      rsp_stored_size,
   input  wire                              rsp_evicted,
   input  wire  [locd_pkg::TOTAL_W-1:0]     rsp_total_bytes,
   output int                               failures,
   output int                               pending,
   output int                               hits_seen,
   output int                               evictions_seen
);

   localparam int ENTRIES   = locd_pkg::ENTRIES_DEF;
   localparam int SLOT_W    = $clog2(ENTRIES);
   localparam int KEY_W     = locd_pkg::KEY_PORT_W;
   localparam int SIZE_W    = locd_pkg::SIZE_W;
   localparam int TOTAL_W   = locd_pkg::TOTAL_W;
   localparam int STAMP_W   = locd_pkg::STAMP_W;
   localparam logic [SIZE_W-1:0]  SIZE_LIMIT = SIZE_W'(locd_pkg::MAX_OBJECT_BYTES_DEF);
   localparam logic [TOTAL_W:0]   TOTAL_CEIL = {1'b0, {TOTAL_W{1'b1}}};

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic [SIZE_W-1:0]   stored_size;
      logic                evicted;
      logic [TOTAL_W-1:0]  total_bytes;
   } directory_result_type;

   // directory copy kept by the checker
   logic                held_valid [ENTRIES];
   logic [KEY_W-1:0]    held_key   [ENTRIES];
   logic [SIZE_W-1:0]   held_size  [ENTRIES];
   logic [STAMP_W-1:0]  held_stamp [ENTRIES];
   logic [STAMP_W-1:0]  use_count;
   logic [TOTAL_W-1:0]  byte_count;

   directory_result_type expected_results [$];
   int                  errors;
   int                  hits;
   int                  evictions;

   initial begin
      errors    = 0;
      hits      = 0;
      evictions = 0;
   end

   // saturating use counter, returns the new stamp
   function automatic logic [STAMP_W-1:0] bump_use_count();
      if (use_count != {STAMP_W{1'b1}}) begin
         use_count = use_count + 1'b1;
      end
      return use_count;
   endfunction

   function automatic directory_result_type predict_directory(logic action,
                                                              logic [KEY_W-1:0] key,
                                                              logic [SIZE_W-1:0] size_in);
      directory_result_type res;
      logic [SIZE_W-1:0]   size;
      logic [STAMP_W-1:0]  oldest;
      logic [TOTAL_W:0]    sum;
      logic                found;
      int                  target;
      int                  i;
      res   = '0;
      found = 1'b0;
      if (action == locd_pkg::ACT_LOOKUP) begin
         for (i = 0; i < ENTRIES; i++) begin
            if (!found && held_valid[i] && held_key[i] == key) begin
               found            = 1'b1;
               held_stamp[i]    = bump_use_count();
               res.hit          = 1'b1;
               res.slot         = SLOT_W'(i);
               res.stored_size  = held_size[i];
            end
         end
      end else begin
         size   = (size_in > SIZE_LIMIT) ? SIZE_LIMIT : size_in;
         target = 0;
         for (i = 0; i < ENTRIES; i++) begin
            if (!found && !held_valid[i]) begin
               found  = 1'b1;
               target = i;
            end
         end
         sum = {1'b0, byte_count};
         if (!found) begin
            // full directory: strictly smallest stamp, lowest index on ties
            oldest = held_stamp[0];
            for (i = 1; i < ENTRIES; i++) begin
               if (held_stamp[i] < oldest) begin
                  oldest = held_stamp[i];
                  target = i;
               end
            end
            res.evicted = 1'b1;
            sum = (sum >= held_size[target]) ? sum - held_size[target] : '0;
         end
         sum = sum + size;
         if (sum > TOTAL_CEIL) begin
            sum = TOTAL_CEIL;
         end
         byte_count         = sum[TOTAL_W-1:0];
         held_valid[target] = 1'b1;
         held_key[target]   = key;
         held_size[target]  = size;
         held_stamp[target] = bump_use_count();
         res.slot           = SLOT_W'(target);
      end
      res.total_bytes = byte_count;
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      directory_result_type want;
      int                   i;
      if (reset) begin
         for (i = 0; i < ENTRIES; i++) begin
            held_valid[i] = 1'b0;
            held_key[i]   = '0;
            held_size[i]  = '0;
            held_stamp[i] = '0;
         end
         use_count  = '0;
         byte_count = '0;
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            want = predict_directory(req_action, req_key, req_object_size);
            if (want.hit) hits++;
            if (want.evicted) evictions++;
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display({"%0t: unexpected item, expected none, ",
                         "actual hit %0d slot %0d size %0d evicted %0d total %0d"},
                        $time, rsp_hit, rsp_slot, rsp_stored_size, rsp_evicted,
                        rsp_total_bytes);
            end else begin
               want = expected_results.pop_front();
               check_field("hit", want.hit, rsp_hit);
               check_field("slot", want.slot, rsp_slot);
               check_field("stored_size", want.stored_size, rsp_stored_size);
               check_field("evicted", want.evicted, rsp_evicted);
               check_field("total_bytes", want.total_bytes, rsp_total_bytes);
            end
         end
      end
      failures       <= errors;
      pending        <= expected_results.size();
      hits_seen      <= hits;
      evictions_seen <= evictions;
   end

endmodule

@@ tb/lru_object_cache_directory_unit_test.sv @@
// testbench top for the cache directory: clock, reset, stimulus, pacing and verdict

module lru_object_cache_directory_unit_test;

   localparam int  SLOT_W      = $clog2(locd_pkg::ENTRIES_DEF);
   localparam int  KEY_W       = locd_pkg::KEY_PORT_W;
   localparam int  SIZE_W      = locd_pkg::SIZE_W;
   localparam int  TOTAL_W     = locd_pkg::TOTAL_W;
   localparam int  MAX_BYTES   = locd_pkg::MAX_OBJECT_BYTES_DEF;
   localparam int  POOL_SIZE   = 24;
   localparam int  RANDOM_ITEMS = 1500;
   localparam int  CYCLE_LIMIT = 200000;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic                req_action      = locd_pkg::ACT_LOOKUP;
   logic [KEY_W-1:0]    req_key         = '0;
   logic [SIZE_W-1:0]   req_object_size = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic                rsp_hit;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [SIZE_W-1:0]   rsp_stored_size;
   logic                rsp_evicted;
   logic [TOTAL_W-1:0]  rsp_total_bytes;

   int                  failures;
   int                  pending;
   int                  hits_seen;
   int                  evictions_seen;
   int                  send_idle_pct = 12;
   int                  recv_idle_pct = 47;
   int                  items_sent    = 0;
   int                  cycle_count   = 0;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   lru_object_cache_directory_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_object_size (req_object_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_stored_size (rsp_stored_size),
      .rsp_evicted     (rsp_evicted),
      .rsp_total_bytes (rsp_total_bytes)
   );

   lru_object_cache_directory_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_object_size (req_object_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_stored_size (rsp_stored_size),
      .rsp_evicted     (rsp_evicted),
      .rsp_total_bytes (rsp_total_bytes),
      .failures        (failures),
      .pending         (pending),
      .hits_seen       (hits_seen),
      .evictions_seen  (evictions_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lru_object_cache_directory_unit_test: FAIL");
         $finish;
      end
   end

   // present one item, with random idle cycles in front, and hold it until taken
   task automatic send_item(logic action, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_key         <= key;
      req_object_size <= size;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic run_random_items(int count);
      logic              action;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
      int                pick;
      int                n;
      for (n = 0; n < count; n++) begin
         // churn part of the key pool now and then so old entries age out
         if (n % 250 == 249) begin
            repeat (4) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom();
         end
         action = ($urandom_range(99) < 55) ? locd_pkg::ACT_LOOKUP : locd_pkg::ACT_INSERT;
         key    = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                             : KEY_W'($urandom());
         pick   = $urandom_range(99);
         if (pick < 3) begin
            size = '0;
         end else if (pick < 9) begin
            size = SIZE_W'($urandom_range((1 << SIZE_W) - 1, MAX_BYTES + 1));
         end else begin
            size = SIZE_W'($urandom_range(MAX_BYTES, 1));
         end
         send_item(action, key, size);
      end
   endtask

   initial begin
      int j;
      for (j = 0; j < POOL_SIZE; j++) begin
         key_pool[j] = $urandom();
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty miss, size extremes, duplicate keys, fill and lru eviction
      send_item(locd_pkg::ACT_LOOKUP, 32'h0000_0000, 17'h1FFFF);
      send_item(locd_pkg::ACT_INSERT, 32'h0000_0000, 17'd0);
      send_item(locd_pkg::ACT_INSERT, 32'hFFFF_FFFF, 17'h1FFFF);
      send_item(locd_pkg::ACT_INSERT, 32'h1234_5678, SIZE_W'(MAX_BYTES));
      send_item(locd_pkg::ACT_INSERT, 32'hA5A5_A5A5, SIZE_W'(MAX_BYTES + 1));
      send_item(locd_pkg::ACT_LOOKUP, 32'h0000_0000, 17'h0AAAA);
      send_item(locd_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 17'h15555);
      send_item(locd_pkg::ACT_INSERT, 32'h0000_0000, 17'd5);
      send_item(locd_pkg::ACT_LOOKUP, 32'h0000_0000, 17'd0);
      for (j = 0; j < 11; j++) begin
         send_item(locd_pkg::ACT_INSERT, 32'h5A00_0000 + j, SIZE_W'(j + 1));
      end
      send_item(locd_pkg::ACT_INSERT, 32'h0F0F_0F0F, 17'd77);
      send_item(locd_pkg::ACT_INSERT, 32'hF0F0_F0F0, 17'd100000);
      send_item(locd_pkg::ACT_LOOKUP, 32'h1234_5678, 17'd1);
      send_item(locd_pkg::ACT_LOOKUP, 32'h5A00_000A, 17'd2);

      // random: three pacing phases
      run_random_items(RANDOM_ITEMS / 3);
      send_idle_pct = 47;
      recv_idle_pct = 12;
      run_random_items(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d items: directed edge cases plus random lookups and inserts",
               items_sent);
      $display("saw %0d lookup hits and %0d evicting inserts over three stall/idle mixes",
               hits_seen, evictions_seen);
      if (failures == 0) begin
         $display("lru_object_cache_directory_unit_test: PASS");
      end else begin
         $display("lru_object_cache_directory_unit_test: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/locd_pkg.sv
hdl/locd_ctrl.sv
hdl/locd_dpath.sv
hdl/lru_object_cache_directory_unit.sv
hdl/locd_checker.sv
tb/lru_object_cache_directory_checker.sv
tb/lru_object_cache_directory_unit_test.sv
